// ----- rtl/brp_pkg.sv -----
// ----------------------------------------------------------------------------
// brp_pkg - base relocation parser shared types and constants
// Relocation type codes, header phase encoding and the patch request that
// passes from the parser to the output stage.
// ----------------------------------------------------------------------------
package brp_pkg;

  localparam int unsigned HW_W       = 16;
  localparam int unsigned ADDR_W     = 64;
  localparam int unsigned DIR_W      = 32;
  localparam int unsigned OFF_W      = 12;
  localparam int unsigned ENTRIES_W  = 31;
  localparam int unsigned CFG_IDX_W  = 2;

  // Relocation entry types (bits 15..12 of an entry)
  localparam logic [3:0] REL_HIGH    = 4'd1;
  localparam logic [3:0] REL_LOW     = 4'd2;
  localparam logic [3:0] REL_HIGHLOW = 4'd3;
  localparam logic [3:0] REL_DIR64   = 4'd10;

  // Minimum legal block size (header only)
  localparam logic [DIR_W-1:0] BLOCK_HDR_BYTES = 32'd8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOAD_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELTA     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_SIZE  = 2'd2;

  // Patch widths as presented on the result channel
  localparam logic [1:0] PW_16 = 2'd0;
  localparam logic [1:0] PW_32 = 2'd1;
  localparam logic [1:0] PW_64 = 2'd2;

  typedef enum logic [4:0] {
    PH_PAGE_LO = 5'b00001,
    PH_PAGE_HI = 5'b00010,
    PH_SIZE_LO = 5'b00100,
    PH_SIZE_HI = 5'b01000,
    PH_ENTRY   = 5'b10000
  } phase_t;

  typedef enum logic [1:0] {
    ADD_LOW16  = 2'd0,
    ADD_HIGH16 = 2'd1,
    ADD_LOW32  = 2'd2,
    ADD_FULL   = 2'd3
  } addend_sel_t;

  typedef struct packed {
    logic              emit;
    addend_sel_t       sel;
    logic [DIR_W:0]    page_off;   // page offset plus entry offset
  } patch_req_t;

endpackage

// ----- rtl/brp_parser.sv -----
// ----------------------------------------------------------------------------
// brp_parser - relocation directory header/entry parser
// Holds the block parsing state and decodes one halfword per step into an
// optional patch request.
// ----------------------------------------------------------------------------
module brp_parser (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step,
  input  logic [brp_pkg::HW_W-1:0]       halfword,
  input  logic                           start_of_directory,
  input  logic [brp_pkg::DIR_W-1:0]      directory_size,
  input  logic                           delta_nz,
  output brp_pkg::patch_req_t            req
);

  brp_pkg::phase_t                   phase_r, phase_nxt, phase_eff;
  logic [brp_pkg::DIR_W-1:0]         page_offset_r, page_offset_nxt, page_offset_eff;
  logic [brp_pkg::HW_W-1:0]          size_low_r, size_low_nxt, size_low_eff;
  logic [brp_pkg::ENTRIES_W-1:0]     entries_left_r, entries_left_nxt, entries_left_eff;
  logic [brp_pkg::DIR_W-1:0]         bytes_consumed_r, bytes_consumed_nxt, bytes_consumed_eff;
  logic                              finished_r, finished_nxt, finished_eff;

  logic [brp_pkg::DIR_W-1:0]         blk_bytes;
  logic [brp_pkg::DIR_W:0]           size_sum;
  logic [brp_pkg::DIR_W-1:0]         size_body;
  logic [brp_pkg::ENTRIES_W-1:0]     entry_count;
  logic [brp_pkg::ENTRIES_W-1:0]     entries_dec;
  logic                              kind_ok;
  brp_pkg::addend_sel_t              sel;

  // start of directory wipes the parser before the halfword is looked at
  always_comb begin
    if (start_of_directory) begin
      phase_eff          = brp_pkg::PH_PAGE_LO;
      page_offset_eff    = '0;
      size_low_eff       = '0;
      entries_left_eff   = '0;
      bytes_consumed_eff = '0;
      finished_eff       = 1'b0;
    end else begin
      phase_eff          = phase_r;
      page_offset_eff    = page_offset_r;
      size_low_eff       = size_low_r;
      entries_left_eff   = entries_left_r;
      bytes_consumed_eff = bytes_consumed_r;
      finished_eff       = finished_r;
    end
  end

  assign blk_bytes   = {halfword, size_low_eff};
  assign size_sum    = {1'b0, bytes_consumed_eff} + {1'b0, blk_bytes};
  assign size_body   = blk_bytes - brp_pkg::BLOCK_HDR_BYTES;
  assign entry_count = size_body[brp_pkg::DIR_W-1:1];
  assign entries_dec = entries_left_eff - 1'b1;

  always_comb begin
    kind_ok = 1'b1;
    sel     = brp_pkg::ADD_FULL;
    case (halfword[15:12])
      brp_pkg::REL_LOW:     sel = brp_pkg::ADD_LOW16;
      brp_pkg::REL_HIGH:    sel = brp_pkg::ADD_HIGH16;
      brp_pkg::REL_HIGHLOW: sel = brp_pkg::ADD_LOW32;
      brp_pkg::REL_DIR64:   sel = brp_pkg::ADD_FULL;
      default:              kind_ok = 1'b0;
    endcase
  end

  always_comb begin
    phase_nxt          = phase_eff;
    page_offset_nxt    = page_offset_eff;
    size_low_nxt       = size_low_eff;
    entries_left_nxt   = entries_left_eff;
    bytes_consumed_nxt = bytes_consumed_eff;
    finished_nxt       = finished_eff;
    req.emit           = 1'b0;
    req.sel            = sel;
    req.page_off       = {1'b0, page_offset_eff} +
                         {{(brp_pkg::DIR_W + 1 - brp_pkg::OFF_W){1'b0}},
                          halfword[brp_pkg::OFF_W-1:0]};
    if (!finished_eff) begin
      case (phase_eff)
        brp_pkg::PH_PAGE_HI: begin
          page_offset_nxt = {halfword, page_offset_eff[15:0]};
          phase_nxt       = brp_pkg::PH_SIZE_LO;
        end
        brp_pkg::PH_SIZE_LO: begin
          size_low_nxt = halfword;
          phase_nxt    = brp_pkg::PH_SIZE_HI;
        end
        brp_pkg::PH_SIZE_HI: begin
          if (blk_bytes < brp_pkg::BLOCK_HDR_BYTES) begin
            finished_nxt = 1'b1;
          end else begin
            bytes_consumed_nxt = size_sum[brp_pkg::DIR_W] ? '1 : size_sum[brp_pkg::DIR_W-1:0];
            entries_left_nxt   = entry_count;
            if (entry_count != '0) begin
              phase_nxt = brp_pkg::PH_ENTRY;
            end else begin
              phase_nxt = brp_pkg::PH_PAGE_LO;
            end
          end
        end
        brp_pkg::PH_ENTRY: begin
          req.emit         = delta_nz && kind_ok;
          entries_left_nxt = entries_dec;
          if (entries_dec == '0) begin
            phase_nxt = brp_pkg::PH_PAGE_LO;
          end
        end
        default: begin
          // new block header, unless the directory is used up
          if (bytes_consumed_eff >= directory_size) begin
            finished_nxt = 1'b1;
          end else begin
            page_offset_nxt = {{(brp_pkg::DIR_W - brp_pkg::HW_W){1'b0}}, halfword};
            phase_nxt       = brp_pkg::PH_PAGE_HI;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= brp_pkg::PH_PAGE_LO;
      page_offset_r    <= '0;
      size_low_r       <= '0;
      entries_left_r   <= '0;
      bytes_consumed_r <= '0;
      finished_r       <= 1'b0;
    end else if (step) begin
      phase_r          <= phase_nxt;
      page_offset_r    <= page_offset_nxt;
      size_low_r       <= size_low_nxt;
      entries_left_r   <= entries_left_nxt;
      bytes_consumed_r <= bytes_consumed_nxt;
      finished_r       <= finished_nxt;
    end
  end

endmodule

// ----- rtl/brp_out_stage.sv -----
// ----------------------------------------------------------------------------
// brp_out_stage - patch command formation and result register
// Adds the load base to the page/entry offset, picks the addend slice of the
// delta and holds the command until the receiver takes it.
// ----------------------------------------------------------------------------
module brp_out_stage (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           take,
  input  brp_pkg::patch_req_t            req,
  input  logic [brp_pkg::ADDR_W-1:0]     load_base,
  input  logic [brp_pkg::ADDR_W-1:0]     reloc_delta,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [brp_pkg::ADDR_W-1:0]     out_patch_address,
  output logic [1:0]                     out_patch_width,
  output logic [brp_pkg::ADDR_W-1:0]     out_addend
);

  logic                          valid_r, valid_nxt;
  logic [brp_pkg::ADDR_W-1:0]    addr_r, addr_nxt;
  logic [1:0]                    width_r, width_nxt;
  logic [brp_pkg::ADDR_W-1:0]    addend_r, addend_nxt;
  logic                          load;

  assign load     = take && req.emit;
  assign addr_nxt = load_base +
                    {{(brp_pkg::ADDR_W - brp_pkg::DIR_W - 1){1'b0}}, req.page_off};

  always_comb begin
    case (req.sel)
      brp_pkg::ADD_LOW16: begin
        width_nxt  = brp_pkg::PW_16;
        addend_nxt = {48'd0, reloc_delta[15:0]};
      end
      brp_pkg::ADD_HIGH16: begin
        width_nxt  = brp_pkg::PW_16;
        addend_nxt = {48'd0, reloc_delta[31:16]};
      end
      brp_pkg::ADD_LOW32: begin
        width_nxt  = brp_pkg::PW_32;
        addend_nxt = {32'd0, reloc_delta[31:0]};
      end
      default: begin
        width_nxt  = brp_pkg::PW_64;
        addend_nxt = reloc_delta;
      end
    endcase
  end

  assign valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      addr_r   <= addr_nxt;
      width_r  <= width_nxt;
      addend_r <= addend_nxt;
    end
  end

  assign out_valid         = valid_r;
  assign out_patch_address = addr_r;
  assign out_patch_width   = width_r;
  assign out_addend        = addend_r;

endmodule

// ----- rtl/base_relocation_parser_core.sv -----
// ----------------------------------------------------------------------------
// base_relocation_parser_core - PE base relocation directory parser
// Turns a halfword stream of the relocation directory into patch commands.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one directory halfword per transaction; in_start_of_directory
//            marks the first halfword and restarts the parser.
//   out_*  : patch commands (address, width code, addend). Entries of other
//            types, header halfwords and anything after the directory end
//            produce no transaction.
//   cfg_*  : register writes (load base, relocation delta, directory size),
//            always ready; write only while the block is idle.
//   A command passes the input register, then the result register, after
//   its halfword is accepted. Throughput: one halfword per cycle while the
//   receiver keeps up; the parser state updates in a single step as the
//   input register drains into the result register.
//   When the receiver stalls, the result register holds, the input register
//   fills and in_ready drops only once both are occupied.
//   Reset (synchronous, active low) empties both registers, zeroes the
//   configuration and leaves the parser expecting a block header.
// ----------------------------------------------------------------------------
module base_relocation_parser_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [brp_pkg::HW_W-1:0]           in_halfword,
  input  logic                               in_start_of_directory,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [brp_pkg::ADDR_W-1:0]         out_patch_address,
  output logic [1:0]                         out_patch_width,
  output logic [brp_pkg::ADDR_W-1:0]         out_addend,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [brp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [brp_pkg::ADDR_W-1:0]         cfg_data
);

  logic                          s0_valid_r, s0_valid_nxt;
  logic [brp_pkg::HW_W-1:0]      s0_hw_r;
  logic                          s0_sod_r;
  logic                          advance;
  logic                          in_acc;

  logic [brp_pkg::ADDR_W-1:0]    load_base_r;
  logic [brp_pkg::ADDR_W-1:0]    reloc_delta_r;
  logic [brp_pkg::DIR_W-1:0]     dir_size_r;

  brp_pkg::patch_req_t           req;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_base_r   <= '0;
      reloc_delta_r <= '0;
      dir_size_r    <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        brp_pkg::CFG_LOAD_BASE: load_base_r   <= cfg_data;
        brp_pkg::CFG_DELTA:     reloc_delta_r <= cfg_data;
        brp_pkg::CFG_DIR_SIZE:  dir_size_r    <= cfg_data[brp_pkg::DIR_W-1:0];
        default: ;
      endcase
    end
  end

  // input register drains whenever the result register is free or emptying
  assign advance      = s0_valid_r && (!out_valid || out_ready);
  assign in_ready     = !s0_valid_r || advance;
  assign in_acc       = in_valid && in_ready;
  assign s0_valid_nxt = in_acc ? 1'b1 : (advance ? 1'b0 : s0_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= s0_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s0_hw_r  <= in_halfword;
      s0_sod_r <= in_start_of_directory;
    end
  end

  brp_parser u_parser (
    .clk                (clk),
    .rst_n              (rst_n),
    .step               (advance),
    .halfword           (s0_hw_r),
    .start_of_directory (s0_sod_r),
    .directory_size     (dir_size_r),
    .delta_nz           (reloc_delta_r != '0),
    .req                (req)
  );

  brp_out_stage u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .take              (advance),
    .req               (req),
    .load_base         (load_base_r),
    .reloc_delta       (reloc_delta_r),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_patch_address (out_patch_address),
    .out_patch_width   (out_patch_width),
    .out_addend        (out_addend)
  );

  // a held halfword must not be overwritten while the result side is stalled
  a_s0_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s0_valid_r && !advance) |=> (s0_valid_r && $stable(s0_hw_r) && $stable(s0_sod_r)))
    else $error("input register lost a pending transaction");

  // no command ever goes out with a zero delta
  a_zero_delta: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && reloc_delta_r == '0) |=> !($rose(out_valid)))
    else $error("patch command emitted with zero delta");

  // 16-bit patches carry a 16-bit addend, 32-bit ones a 32-bit addend
  a_addend_width: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_patch_width == brp_pkg::PW_16 && out_addend[63:16] == '0) ||
                   (out_patch_width == brp_pkg::PW_32 && out_addend[63:32] == '0) ||
                   (out_patch_width == brp_pkg::PW_64)))
    else $error("addend does not fit the patch width");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !s0_valid_r))
    else $error("pipeline not empty after reset");

endmodule
